// ----- rtl/box_overlap_metrics_unit_macros.svh -----
// ----------------------------------------------------------------------------
// box_overlap_metrics_unit_macros
// Assertion macros for the box overlap metrics unit.
// Each macro expects aclk and aresetn to be visible where it is used.
// ----------------------------------------------------------------------------
`ifndef BOX_OVERLAP_METRICS_UNIT_MACROS_SVH
`define BOX_OVERLAP_METRICS_UNIT_MACROS_SVH

// Same-cycle implication, disabled in reset
`define BOM_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled in reset
`define BOM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/bom_pkg.sv -----
// ----------------------------------------------------------------------------
// bom_pkg
// Widths and latency constants shared by the box overlap metrics unit.
// ----------------------------------------------------------------------------
package bom_pkg;

    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 16;

    localparam int SIZE_BITS  = COORD_BITS - 1;
    localparam int AREA_BITS  = 2 * SIZE_BITS;
    localparam int SUM_BITS   = AREA_BITS + 1;
    localparam int RATIO_BITS = FRAC_BITS + 1;
    localparam int DIV_STAGES = FRAC_BITS + 1;

    // Pipeline control shared by the front end and the dividers
    typedef struct packed {
        logic advance;
    } pipe_ctrl_t;

endpackage

// ----- rtl/box_overlap_metrics_unit.sv -----
// ----------------------------------------------------------------------------
// box_overlap_metrics_unit
// Overlap flag, intersection and union areas and Q16 match ratios per box pair.
// ----------------------------------------------------------------------------
// One box pair is taken per cycle unless the result side stalls, and each
// request passes through four front stages (box edges, clamped intersection
// size, area products, area sums) and one stage per quotient bit in each of
// the four pipelined dividers, 21 register stages in all, the first written
// at the accepting edge. All stages advance together whenever the output
// register is empty or being taken, so a stall on the result side holds every
// request in place.
module box_overlap_metrics_unit (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [bom_pkg::COORD_BITS-1:0] s_det_first_column,
    input  logic signed [bom_pkg::COORD_BITS-1:0] s_det_first_line,
    input  logic [bom_pkg::SIZE_BITS-1:0]        s_det_width,
    input  logic [bom_pkg::SIZE_BITS-1:0]        s_det_height,
    input  logic signed [bom_pkg::COORD_BITS-1:0] s_gt_first_column,
    input  logic signed [bom_pkg::COORD_BITS-1:0] s_gt_first_line,
    input  logic [bom_pkg::SIZE_BITS-1:0]        s_gt_width,
    input  logic [bom_pkg::SIZE_BITS-1:0]        s_gt_height,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic                                 m_overlapping,
    output logic [bom_pkg::AREA_BITS-1:0]        m_overlap_area,
    output logic [bom_pkg::SUM_BITS-1:0]         m_combined_area,
    output logic [bom_pkg::RATIO_BITS-1:0]       m_precision_ratio,
    output logic [bom_pkg::RATIO_BITS-1:0]       m_recall_ratio,
    output logic [bom_pkg::RATIO_BITS-1:0]       m_iou_ratio,
    output logic [bom_pkg::RATIO_BITS-1:0]       m_f_ratio
);
    import bom_pkg::*;

    localparam int EW     = COORD_BITS + 1;
    localparam int DW     = COORD_BITS + 2;
    localparam int STAGES = 4 + DIV_STAGES;

    pipe_ctrl_t ctrl;
    logic       vld_reg [STAGES];

    // Stage 1: edges and overlap test
    logic signed [EW-1:0] dc, dl, gc, gl, dlc, dll, glc, gll;
    logic signed [EW-1:0] maxc_reg, maxl_reg, minlc_reg, minll_reg;
    logic                 ov1_reg;
    logic [SIZE_BITS-1:0] dw1_reg, dh1_reg, gw1_reg, gh1_reg;

    // Stage 2: clamped intersection size
    logic signed [DW-1:0] iw_raw, ih_raw;
    logic [SIZE_BITS-1:0] iw_reg, ih_reg, dw2_reg, dh2_reg, gw2_reg, gh2_reg;
    logic                 ov2_reg;

    // Stage 3: areas
    logic [AREA_BITS-1:0] ia3_reg, da3_reg, ga3_reg;
    logic                 ov3_reg;

    // Stage 4: sums
    logic [SUM_BITS-1:0]  ia4_reg, da4_reg, ga4_reg, ua4_reg, ia2_reg, sum_reg;
    logic                 ov4_reg;

    // Side band riding with the dividers
    logic                 ov_dly_reg [DIV_STAGES];
    logic [AREA_BITS-1:0] ia_dly_reg [DIV_STAGES];
    logic [SUM_BITS-1:0]  ua_dly_reg [DIV_STAGES];

    logic [RATIO_BITS-1:0] prec_q, rec_q, iou_q, f_q;

    // Advance the whole pipeline unless the output is held
    assign ctrl.advance = !vld_reg[STAGES-1] || m_ready;
    assign s_ready      = ctrl.advance;

    assign dc  = EW'(s_det_first_column);
    assign dl  = EW'(s_det_first_line);
    assign gc  = EW'(s_gt_first_column);
    assign gl  = EW'(s_gt_first_line);
    assign dlc = dc + $signed({2'b00, s_det_width}) - EW'(1);
    assign dll = dl + $signed({2'b00, s_det_height}) - EW'(1);
    assign glc = gc + $signed({2'b00, s_gt_width}) - EW'(1);
    assign gll = gl + $signed({2'b00, s_gt_height}) - EW'(1);

    assign iw_raw = DW'(minlc_reg) - DW'(maxc_reg) + DW'(1);
    assign ih_raw = DW'(minll_reg) - DW'(maxl_reg) + DW'(1);

    // Track the valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < STAGES; k++) vld_reg[k] <= 1'b0;
        end else if (ctrl.advance) begin
            vld_reg[0] <= s_valid;
            for (int k = 1; k < STAGES; k++) vld_reg[k] <= vld_reg[k-1];
        end
    end

    // Advance the front stages and the side band
    always_ff @(posedge aclk) begin
        if (ctrl.advance) begin
            maxc_reg  <= (dc > gc) ? dc : gc;
            maxl_reg  <= (dl > gl) ? dl : gl;
            minlc_reg <= (dlc < glc) ? dlc : glc;
            minll_reg <= (dll < gll) ? dll : gll;
            ov1_reg   <= !(((dc < gc) && (dlc < gc)) || ((gc < dc) && (glc < dc)) ||
                           ((dl < gl) && (dll < gl)) || ((gl < dl) && (gll < dl)));
            dw1_reg   <= s_det_width;
            dh1_reg   <= s_det_height;
            gw1_reg   <= s_gt_width;
            gh1_reg   <= s_gt_height;

            iw_reg  <= (iw_raw > 0) ? iw_raw[SIZE_BITS-1:0] : '0;
            ih_reg  <= (ih_raw > 0) ? ih_raw[SIZE_BITS-1:0] : '0;
            dw2_reg <= dw1_reg;
            dh2_reg <= dh1_reg;
            gw2_reg <= gw1_reg;
            gh2_reg <= gh1_reg;
            ov2_reg <= ov1_reg;

            ia3_reg <= iw_reg * ih_reg;
            da3_reg <= dw2_reg * dh2_reg;
            ga3_reg <= gw2_reg * gh2_reg;
            ov3_reg <= ov2_reg;

            ia4_reg <= SUM_BITS'(ia3_reg);
            da4_reg <= SUM_BITS'(da3_reg);
            ga4_reg <= SUM_BITS'(ga3_reg);
            ua4_reg <= SUM_BITS'(da3_reg) + SUM_BITS'(ga3_reg) - SUM_BITS'(ia3_reg);
            ia2_reg <= {ia3_reg, 1'b0};
            sum_reg <= SUM_BITS'(da3_reg) + SUM_BITS'(ga3_reg);
            ov4_reg <= ov3_reg;

            ov_dly_reg[0] <= ov4_reg;
            ia_dly_reg[0] <= ia4_reg[AREA_BITS-1:0];
            ua_dly_reg[0] <= ua4_reg;
            for (int k = 1; k < DIV_STAGES; k++) begin
                ov_dly_reg[k] <= ov_dly_reg[k-1];
                ia_dly_reg[k] <= ia_dly_reg[k-1];
                ua_dly_reg[k] <= ua_dly_reg[k-1];
            end
        end
    end

    bom_qdiv u_div_prec (.aclk(aclk), .ctrl(ctrl), .num(ia4_reg), .den(da4_reg), .quo(prec_q));
    bom_qdiv u_div_rec  (.aclk(aclk), .ctrl(ctrl), .num(ia4_reg), .den(ga4_reg), .quo(rec_q));
    bom_qdiv u_div_iou  (.aclk(aclk), .ctrl(ctrl), .num(ia4_reg), .den(ua4_reg), .quo(iou_q));
    bom_qdiv u_div_f    (.aclk(aclk), .ctrl(ctrl), .num(ia2_reg), .den(sum_reg), .quo(f_q));

    // Drive the result request
    assign m_valid           = vld_reg[STAGES-1];
    assign m_overlapping     = ov_dly_reg[DIV_STAGES-1];
    assign m_overlap_area    = ia_dly_reg[DIV_STAGES-1];
    assign m_combined_area   = ua_dly_reg[DIV_STAGES-1];
    assign m_precision_ratio = prec_q;
    assign m_recall_ratio    = rec_q;
    assign m_iou_ratio       = iou_q;
    assign m_f_ratio         = ov_dly_reg[DIV_STAGES-1] ? f_q : '0;

endmodule

// ----- rtl/bom_qdiv.sv -----
// ----------------------------------------------------------------------------
// bom_qdiv
// Pipelined restoring divider: floor(num * 2^FRAC_BITS / den), num <= den,
// one quotient bit per stage, zero when the denominator is zero.
// ----------------------------------------------------------------------------
module bom_qdiv (
    input  logic                            aclk,
    input  bom_pkg::pipe_ctrl_t             ctrl,
    input  logic [bom_pkg::SUM_BITS-1:0]    num,
    input  logic [bom_pkg::SUM_BITS-1:0]    den,
    output logic [bom_pkg::RATIO_BITS-1:0]  quo
);
    import bom_pkg::*;

    localparam int RW = SUM_BITS + 1;

    logic [RW-1:0]         r_reg    [DIV_STAGES];
    logic [RATIO_BITS-1:0] q_reg    [DIV_STAGES];
    logic [SUM_BITS-1:0]   den_reg  [DIV_STAGES];
    logic                  zero_reg [DIV_STAGES];

    logic [RW-1:0]         r_next   [DIV_STAGES];
    logic [RATIO_BITS-1:0] q_next   [DIV_STAGES];

    // Work out each stage's partial remainder and quotient
    always_comb begin
        logic [RW-1:0] sh;
        logic          bit_q;
        bit_q     = (num >= den);
        r_next[0] = bit_q ? RW'(num - den) : RW'(num);
        q_next[0] = {{(RATIO_BITS-1){1'b0}}, bit_q};
        for (int k = 1; k < DIV_STAGES; k++) begin
            sh        = {r_reg[k-1][RW-2:0], 1'b0};
            bit_q     = (sh >= {1'b0, den_reg[k-1]});
            r_next[k] = bit_q ? (sh - {1'b0, den_reg[k-1]}) : sh;
            q_next[k] = {q_reg[k-1][RATIO_BITS-2:0], bit_q};
        end
    end

    // Advance the divider stages
    always_ff @(posedge aclk) begin
        if (ctrl.advance) begin
            r_reg[0]    <= r_next[0];
            q_reg[0]    <= q_next[0];
            den_reg[0]  <= den;
            zero_reg[0] <= (den == '0);
            for (int k = 1; k < DIV_STAGES; k++) begin
                r_reg[k]    <= r_next[k];
                q_reg[k]    <= q_next[k];
                den_reg[k]  <= den_reg[k-1];
                zero_reg[k] <= zero_reg[k-1];
            end
        end
    end

    assign quo = zero_reg[DIV_STAGES-1] ? '0 : q_reg[DIV_STAGES-1];

endmodule

// ----- rtl/box_overlap_metrics_unit_checker.sv -----
// ----------------------------------------------------------------------------
// box_overlap_metrics_unit_checker
// Port-level checks on flow control and result ranges, bound to the top level.
// ----------------------------------------------------------------------------
`include "box_overlap_metrics_unit_macros.svh"

module box_overlap_metrics_unit_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_ready,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic                                m_overlapping,
    input logic [bom_pkg::AREA_BITS-1:0]       m_overlap_area,
    input logic [bom_pkg::SUM_BITS-1:0]        m_combined_area,
    input logic [bom_pkg::RATIO_BITS-1:0]      m_precision_ratio,
    input logic [bom_pkg::RATIO_BITS-1:0]      m_iou_ratio,
    input logic [bom_pkg::RATIO_BITS-1:0]      m_f_ratio
);
    import bom_pkg::*;

    localparam logic [RATIO_BITS-1:0] ONE_Q = RATIO_BITS'(1) << FRAC_BITS;

    // A held result keeps its request
    `BOM_ASSERT_NEXT(a_hold_valid, m_valid && !m_ready, m_valid && $stable(m_combined_area))
    // Input is taken whenever the output can move
    `BOM_ASSERT_NOW(a_ready_flow, !m_valid || m_ready, s_ready)
    // The union always covers the intersection, precision and IoU ratios never exceed one
    `BOM_ASSERT_NOW(a_area_order, m_valid, {1'b0, m_overlap_area} <= m_combined_area)
    `BOM_ASSERT_NOW(a_ratio_range, m_valid, m_precision_ratio <= ONE_Q && m_iou_ratio <= ONE_Q)
    // F-measure is zero for separated boxes
    `BOM_ASSERT_NOW(a_f_zero, m_valid && !m_overlapping, m_f_ratio == '0)

endmodule

bind box_overlap_metrics_unit box_overlap_metrics_unit_checker u_checker (
    .aclk(aclk), .aresetn(aresetn), .s_ready(s_ready), .m_valid(m_valid),
    .m_ready(m_ready), .m_overlapping(m_overlapping),
    .m_overlap_area(m_overlap_area), .m_combined_area(m_combined_area),
    .m_precision_ratio(m_precision_ratio), .m_iou_ratio(m_iou_ratio),
    .m_f_ratio(m_f_ratio)
);
